// ===== hw/rtl/cgs_pkg.sv =====
package cgs_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // reset values of the configuration registers
  localparam logic [10:0] BUF_ROWS_RST = 11'd1024;
  localparam logic [10:0] BUF_COLS_RST = 11'd1024;

  typedef enum logic [1:0] {
    REG_BUF_ROWS  = 2'd0,
    REG_BUF_COLS  = 2'd1,
    REG_START_ROW = 2'd2,
    REG_START_COL = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] buffer_rows;
    logic [10:0] buffer_cols;
    logic [9:0]  start_row;
    logic [9:0]  start_col;
  } cfg_t;

  typedef struct packed {
    logic [9:0]  top_left_row;
    logic [9:0]  top_left_col;
    logic [10:0] submap_rows;
    logic [10:0] submap_cols;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [9:0]  region_row;
    logic [9:0]  region_col;
    logic [10:0] region_rows;
    logic [10:0] region_cols;
    logic [1:0]  quadrant;
    logic        last;
  } rsp_t;

endpackage

// ===== hw/rtl/cgs_split.sv =====
module cgs_split import cgs_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  cfg_t           cfg,
  input  req_t           req,
  output logic [2:0]     cnt,
  output rsp_t [3:0]     ent
);

  logic        bad_size, bad_start, bad_tl, empty, past, impossible, fail;
  logic [11:0] ur, uc;
  logic [11:0] br_row_raw, br_col_raw, br_row, br_col;
  logic        tl_top, tl_left, br_top, br_left;
  logic        row_split, col_split, both;
  logic [10:0] r1, c1, r2, c2;
  logic [1:0]  q;
  rsp_t        p_tl, p_col, p_row, p_both, p_fail;

  always_comb begin
    bad_size = (cfg.buffer_rows == '0) || (cfg.buffer_cols == '0) ||
               (int'(cfg.buffer_rows) > MAX_DIM) || (int'(cfg.buffer_cols) > MAX_DIM);
    bad_start = ({1'b0, cfg.start_row} >= cfg.buffer_rows) ||
                ({1'b0, cfg.start_col} >= cfg.buffer_cols);
    bad_tl = ({1'b0, req.top_left_row} >= cfg.buffer_rows) ||
             ({1'b0, req.top_left_col} >= cfg.buffer_cols);
    empty = (req.submap_rows == '0) || (req.submap_cols == '0);

    tl_top  = req.top_left_row >= cfg.start_row;
    tl_left = req.top_left_col >= cfg.start_col;

    // map-order position of the top-left cell
    ur = tl_top ? 12'(req.top_left_row) - 12'(cfg.start_row)
                : 12'(req.top_left_row) + 12'(cfg.buffer_rows) - 12'(cfg.start_row);
    uc = tl_left ? 12'(req.top_left_col) - 12'(cfg.start_col)
                 : 12'(req.top_left_col) + 12'(cfg.buffer_cols) - 12'(cfg.start_col);
    past = (13'(ur) + 13'(req.submap_rows) > 13'(cfg.buffer_rows)) ||
           (13'(uc) + 13'(req.submap_cols) > 13'(cfg.buffer_cols));

    // bottom-right corner, wrapped at most once
    br_row_raw = 12'(req.top_left_row) + 12'(req.submap_rows) - 12'd1;
    br_col_raw = 12'(req.top_left_col) + 12'(req.submap_cols) - 12'd1;
    br_row = (br_row_raw >= 12'(cfg.buffer_rows)) ?
             br_row_raw - 12'(cfg.buffer_rows) : br_row_raw;
    br_col = (br_col_raw >= 12'(cfg.buffer_cols)) ?
             br_col_raw - 12'(cfg.buffer_cols) : br_col_raw;
    br_top  = br_row >= 12'(cfg.start_row);
    br_left = br_col >= 12'(cfg.start_col);

    impossible = (!tl_top && br_top) || (!tl_left && br_left);
    fail = bad_size || bad_start || bad_tl || empty || past || impossible;

    row_split = tl_top && !br_top;
    col_split = tl_left && !br_left;
    both      = row_split && col_split;
    q = {!tl_top, !tl_left};

    r1 = row_split ? cfg.buffer_rows - {1'b0, req.top_left_row} : req.submap_rows;
    c1 = col_split ? cfg.buffer_cols - {1'b0, req.top_left_col} : req.submap_cols;
    r2 = req.submap_rows - r1;
    c2 = req.submap_cols - c1;

    p_tl   = '{ok: 1'b1, region_row: req.top_left_row, region_col: req.top_left_col,
               region_rows: r1, region_cols: c1, quadrant: q, last: 1'b0};
    p_col  = '{ok: 1'b1, region_row: req.top_left_row, region_col: '0,
               region_rows: r1, region_cols: c2, quadrant: q | 2'b01, last: 1'b0};
    p_row  = '{ok: 1'b1, region_row: '0, region_col: req.top_left_col,
               region_rows: r2, region_cols: c1, quadrant: q | 2'b10, last: 1'b0};
    p_both = '{ok: 1'b1, region_row: '0, region_col: '0,
               region_rows: r2, region_cols: c2, quadrant: 2'b11, last: 1'b0};
    p_fail = '0;

    // packed in emit order; the shifter in the top level takes entry 0 first
    if (fail) begin
      cnt = 3'd1;
      ent = {p_fail, p_fail, p_fail, p_fail};
    end else begin
      cnt = 3'd1 + 3'(col_split) + 3'(row_split) + 3'(both);
      ent = {p_both, p_row, (col_split ? p_col : p_row), p_tl};
    end
  end

endmodule

// ===== hw/rtl/circular_grid_submap_region_split.sv =====
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------
// request   | start in, busy out     | in_data  (req_t)
// result    | out_strobe out         | out_data (rsp_t), one beat/cycle
// config    | APB psel/penable/...   | pwdata/prdata, 4 regs at 4*i
//
// A request is registered, split combinationally into 1, 2 or 4 regions and
// loaded into a four-entry shifter, from which its first beat shows. One
// beat leaves per cycle, so a request occupies the result port for 1, 2 or
// 4 beats, and busy is high while the shifter still holds more than one
// beat and a request waits behind it. Results cannot be stalled.
// Reset (synchronous, rst_n low) clears the pipeline and loads the
// register defaults.
module circular_grid_submap_region_split import cgs_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  req_t              in_data,
  output logic              out_strobe,
  output rsp_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg_r, cfg_nxt;
  logic       req_v_r, req_v_nxt;
  req_t       req_r, req_nxt;
  rsp_t [3:0] q_r, q_nxt;
  logic [2:0] rem_r, rem_nxt;

  logic       accept, load, wr_en;
  logic [2:0] split_cnt;
  rsp_t [3:0] split_ent;
  reg_idx_t   idx;

  cgs_split #(.MAX_DIM(MAX_DIM)) u_split (
    .cfg (cfg_r),
    .req (req_r),
    .cnt (split_cnt),
    .ent (split_ent)
  );

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (idx)
      REG_BUF_ROWS:  prdata = DATA_W'(cfg_r.buffer_rows);
      REG_BUF_COLS:  prdata = DATA_W'(cfg_r.buffer_cols);
      REG_START_ROW: prdata = DATA_W'(cfg_r.start_row);
      REG_START_COL: prdata = DATA_W'(cfg_r.start_col);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_BUF_ROWS:  cfg_nxt.buffer_rows = pwdata[10:0];
        REG_BUF_COLS:  cfg_nxt.buffer_cols = pwdata[10:0];
        REG_START_ROW: cfg_nxt.start_row   = pwdata[9:0];
        REG_START_COL: cfg_nxt.start_col   = pwdata[9:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  // the shifter frees up when at most its final beat remains
  assign load   = req_v_r && (rem_r <= 3'd1);
  assign busy   = req_v_r && (rem_r > 3'd1);
  assign accept = start && !busy;

  always_comb begin
    req_nxt   = accept ? in_data : req_r;
    req_v_nxt = accept || (req_v_r && !load);
    if (load) begin
      q_nxt   = split_ent;
      rem_nxt = split_cnt;
    end else begin
      q_nxt      = {q_r[3], q_r[3:1]};
      rem_nxt    = (rem_r != '0) ? rem_r - 3'd1 : rem_r;
    end
  end

  always_comb begin
    out_strobe    = rem_r != '0;
    out_data      = q_r[0];
    out_data.last = rem_r == 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= '{buffer_rows: BUF_ROWS_RST, buffer_cols: BUF_COLS_RST,
                   start_row: '0, start_col: '0};
      req_v_r <= 1'b0;
      rem_r   <= '0;
    end else begin
      cfg_r   <= cfg_nxt;
      req_v_r <= req_v_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    q_r   <= q_nxt;
  end

endmodule

// ===== hw/rtl/cgs_checker.sv =====
module cgs_checker import cgs_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_strobe,
  input rsp_t out_data
);

  // busy only while a multi-beat request is draining
  a_busy_draining: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> out_strobe && !out_data.last)
    else $error("busy without a pending beat");

  // beats of one request are contiguous
  a_burst_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.last |=> out_strobe)
    else $error("result burst broken");

  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.ok |-> out_data.last)
    else $error("failure beat not last");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.ok |->
      out_data.region_row == '0 && out_data.region_col == '0 &&
      out_data.region_rows == '0 && out_data.region_cols == '0 &&
      out_data.quadrant == '0)
    else $error("failure beat carries region data");

endmodule

bind circular_grid_submap_region_split cgs_checker u_cgs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import cgs_pkg::*;

  localparam int MAX_DIM    = 1024;
  localparam int IDLE_LIMIT = 500;
  localparam int RAND_PHASES = 6;
  localparam int RAND_ITEMS  = 58;

  localparam logic [1:0] Q_TOP_LEFT  = 2'd0;
  localparam logic [1:0] Q_TOP_RIGHT = 2'd1;
  localparam logic [1:0] Q_BOT_LEFT  = 2'd2;
  localparam logic [1:0] Q_BOT_RIGHT = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  req_t              in_data;
  logic              out_strobe;
  rsp_t              out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cfg_t geom;                 // shadow of the register file
  rsp_t expected_regions[$];
  int   mismatch_count;
  int   idle_cycles;

  circular_grid_submap_region_split #(
    .MAX_DIM(MAX_DIM)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Region prediction
  // ---------------------------------------------------------------------------
  function automatic void queue_beat(input rsp_t b);
    expected_regions = {expected_regions, b};
  endfunction

  function automatic void predict_regions(input req_t r);
    int   rows, cols, srow, scol, tr, tc, sr, sc, ur, uc;
    int   br_r, br_c, r1, c1, n;
    bit   tl_top, tl_left, br_top, br_left, rsplit, csplit;
    logic [1:0] q;
    rsp_t beats[4];
    rows = geom.buffer_rows;
    cols = geom.buffer_cols;
    srow = geom.start_row;
    scol = geom.start_col;
    tr   = r.top_left_row;
    tc   = r.top_left_col;
    sr   = r.submap_rows;
    sc   = r.submap_cols;
    ur   = (tr >= srow) ? tr - srow : tr + rows - srow;
    uc   = (tc >= scol) ? tc - scol : tc + cols - scol;
    for (int k = 0; k < 4; k++) beats[k] = '0;
    beats[0].last = 1'b1;
    if (rows == 0 || cols == 0 || rows > MAX_DIM || cols > MAX_DIM ||
        srow >= rows || scol >= cols || tr >= rows || tc >= cols ||
        sr == 0 || sc == 0 || ur + sr > rows || uc + sc > cols) begin
      queue_beat(beats[0]);
      return;
    end
    br_r = tr + sr - 1;
    if (br_r >= rows) br_r -= rows;
    br_c = tc + sc - 1;
    if (br_c >= cols) br_c -= cols;
    tl_top  = tr >= srow;
    tl_left = tc >= scol;
    br_top  = br_r >= srow;
    br_left = br_c >= scol;
    // corners in quadrants that cannot bound one submap
    if ((!tl_top && br_top) || (!tl_left && br_left)) begin
      queue_beat(beats[0]);
      return;
    end
    rsplit = tl_top && !br_top;
    csplit = tl_left && !br_left;
    q  = tl_top ? (tl_left ? Q_TOP_LEFT : Q_TOP_RIGHT)
                : (tl_left ? Q_BOT_LEFT : Q_BOT_RIGHT);
    r1 = rsplit ? rows - tr : sr;
    c1 = csplit ? cols - tc : sc;
    n  = 0;
    beats[n] = '{1'b1, 10'(tr), 10'(tc), 11'(r1), 11'(c1), q, 1'b0};
    n++;
    if (csplit) begin
      beats[n] = '{1'b1, 10'(tr), 10'd0, 11'(r1), 11'(sc - c1), q | Q_TOP_RIGHT, 1'b0};
      n++;
    end
    if (rsplit) begin
      beats[n] = '{1'b1, 10'd0, 10'(tc), 11'(sr - r1), 11'(c1), q | Q_BOT_LEFT, 1'b0};
      n++;
    end
    if (rsplit && csplit) begin
      beats[n] = '{1'b1, 10'd0, 10'd0, 11'(sr - r1), 11'(sc - c1), Q_BOT_RIGHT, 1'b0};
      n++;
    end
    beats[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) queue_beat(beats[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void flag_beat(input bit have_want, input rsp_t want, input rsp_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (have_want)
        $display("mismatch: want ok=%0d r=%0d c=%0d nr=%0d nc=%0d q=%0d last=%0d",
                 want.ok, want.region_row, want.region_col, want.region_rows,
                 want.region_cols, want.quadrant, want.last);
      else
        $display("mismatch: beat with nothing pending");
      $display("          got  ok=%0d r=%0d c=%0d nr=%0d nc=%0d q=%0d last=%0d",
               got.ok, got.region_row, got.region_col, got.region_rows,
               got.region_cols, got.quadrant, got.last);
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_strobe) begin
      if (expected_regions.size() == 0) begin
        flag_beat(1'b0, '0, out_data);
      end else begin
        want = expected_regions.pop_front();
        if (out_data.ok !== want.ok || out_data.region_row !== want.region_row ||
            out_data.region_col !== want.region_col ||
            out_data.region_rows !== want.region_rows ||
            out_data.region_cols !== want.region_cols ||
            out_data.quadrant !== want.quadrant || out_data.last !== want.last)
          flag_beat(1'b1, want, out_data);
      end
    end
  end

  // stall watchdog: any beat on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_req(input req_t r);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (busy);
    predict_regions(r);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // hold off the sender until every pending region has come out
  task automatic drain_regions();
    @(negedge clk);
    start <= 1'b0;
    while (expected_regions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BUF_ROWS:  geom.buffer_rows = val[10:0];
      REG_BUF_COLS:  geom.buffer_cols = val[10:0];
      REG_START_ROW: geom.start_row   = val[9:0];
      REG_START_COL: geom.start_col   = val[9:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_geometry(input int rows, input int cols, input int srow, input int scol);
    drain_regions();
    write_reg(REG_BUF_ROWS,  DATA_W'(rows));
    write_reg(REG_BUF_COLS,  DATA_W'(cols));
    write_reg(REG_START_ROW, DATA_W'(srow));
    write_reg(REG_START_COL, DATA_W'(scol));
  endtask

  function automatic req_t mk_req(input int tr, input int tc, input int sr, input int sc);
    mk_req = '{10'(tr), 10'(tc), 11'(sr), 11'(sc)};
  endfunction

  function automatic bit geom_valid();
    geom_valid = geom.buffer_rows >= 1 && geom.buffer_rows <= MAX_DIM &&
                 geom.buffer_cols >= 1 && geom.buffer_cols <= MAX_DIM &&
                 geom.start_row < geom.buffer_rows && geom.start_col < geom.buffer_cols;
  endfunction

  // mostly submaps that fit the map; the rest is raw noise
  function automatic req_t random_req();
    int rows, cols, tr, tc, ur, uc, sr, sc;
    req_t r;
    if (!geom_valid() || $urandom_range(0, 99) < 15) begin
      r.top_left_row = 10'($urandom);
      r.top_left_col = 10'($urandom);
      r.submap_rows  = 11'($urandom);
      r.submap_cols  = 11'($urandom);
      if ($urandom_range(0, 1)) r.submap_rows = 11'($urandom_range(0, 40));
      if ($urandom_range(0, 1)) r.submap_cols = 11'($urandom_range(0, 40));
      return r;
    end
    rows = geom.buffer_rows;
    cols = geom.buffer_cols;
    tr = $urandom_range(0, rows - 1);
    tc = $urandom_range(0, cols - 1);
    ur = (tr >= geom.start_row) ? tr - geom.start_row : tr + rows - geom.start_row;
    uc = (tc >= geom.start_col) ? tc - geom.start_col : tc + cols - geom.start_col;
    sr = ($urandom_range(0, 3) == 0) ? rows - ur : $urandom_range(1, rows - ur);
    sc = ($urandom_range(0, 3) == 0) ? cols - uc : $urandom_range(1, cols - uc);
    return mk_req(tr, tc, sr, sc);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_default_map();
    send_req(mk_req(0, 0, 1024, 1024));
    send_req(mk_req(1023, 1023, 1, 1));
    send_req(mk_req(1023, 0, 2, 1));       // runs past the last row
    send_req(mk_req(5, 5, 0, 3));          // empty
    send_req(mk_req(0, 0, 2047, 2047));
    send_req(mk_req(512, 700, 1025, 1));
  endtask

  task automatic test_wrapped_regions();
    set_geometry(10, 12, 4, 5);
    send_req(mk_req(6, 7, 8, 10));         // splits both ways
    send_req(mk_req(6, 7, 2, 10));         // column wrap only
    send_req(mk_req(6, 7, 8, 3));          // row wrap only
    send_req(mk_req(2, 3, 2, 2));          // bottom-right quadrant
    send_req(mk_req(4, 5, 10, 12));        // whole map from the start cell
    send_req(mk_req(10, 0, 1, 1));         // corner outside buffer
    send_req(mk_req(0, 12, 1, 1));
    send_req(mk_req(1023, 1023, 1, 1));
    send_req(mk_req(8, 9, 7, 1));          // past the map edge
  endtask

  task automatic test_bad_geometry();
    set_geometry(0, 12, 0, 0);
    send_req(mk_req(0, 0, 1, 1));
    set_geometry(1500, 12, 0, 0);
    send_req(mk_req(0, 0, 1, 1));
    set_geometry(10, 2047, 0, 0);
    send_req(mk_req(0, 0, 1, 1));
    set_geometry(5, 7, 5, 0);              // start row outside buffer
    send_req(mk_req(0, 0, 1, 1));
    set_geometry(5, 7, 0, 7);
    send_req(mk_req(0, 0, 1, 1));
  endtask

  task automatic test_extreme_geometry();
    set_geometry(1, 1, 0, 0);
    send_req(mk_req(0, 0, 1, 1));
    send_req(mk_req(0, 0, 1, 2));
    set_geometry(1024, 1024, 1023, 1023);
    send_req(mk_req(1023, 1023, 1024, 1024));
    send_req(mk_req(0, 0, 1, 1));
  endtask

  task automatic test_random_requests();
    int rows, cols, srow, scol, burst;
    for (int p = 0; p < RAND_PHASES; p++) begin
      rows = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 16);
      cols = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 16);
      srow = $urandom_range(0, rows - 1);
      scol = $urandom_range(0, cols - 1);
      if ($urandom_range(0, 7) == 0) srow = $urandom_range(0, 1023);
      set_geometry(rows, cols, srow, scol);
      burst = 0;
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          if ($urandom_range(0, 29) == 0) drain_regions();
          else if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
        end
        send_req(random_req());
        burst--;
      end
    end
  endtask

  initial begin
    clk     = 1'b0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    geom = '{BUF_ROWS_RST, BUF_COLS_RST, 10'd0, 10'd0};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_map();
    test_wrapped_regions();
    test_bad_geometry();
    test_extreme_geometry();
    test_random_requests();

    drain_regions();
    repeat (10) @(posedge clk);
    mismatch_count += expected_regions.size();
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
